@@ hw/rtl/twis_pkg.sv @@
// Package for the trie word insert and search block.
// Holds the default sizes, the field widths, the op codes and the status codes.
// Depends on nothing.
package twis_pkg;

   localparam int DEFAULT_NODES    = 256;
   localparam int DEFAULT_WORD_MAX = 15;
   localparam int DEFAULT_ALPHABET = 26;

   localparam int LETTER_W = 5;
   localparam int STATUS_W = 2;

   typedef logic [STATUS_W-1:0] status_type;

   localparam status_type STATUS_OK        = 2'd0;
   localparam status_type STATUS_NOT_FOUND = 2'd1;
   localparam status_type STATUS_POOL_FULL = 2'd2;
   localparam status_type STATUS_TOO_LONG  = 2'd3;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

endpackage

@@ hw/rtl/twis_ram.sv @@
// Simple dual-port synchronous RAM with one write port and one registered read port.
// Used for the child table and the word-end marks; depends on nothing.
module twis_ram #(
   parameter int DEPTH  = 256,
   parameter int ADDR_W = 8,
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/trie_word_insert_search_top.sv @@
// Top level of the trie word insert and search block: control sequencer and memories.
// Depends on twis_pkg and twis_ram.
//
// Usage. Words enter on the req_ channel one letter per item, each with an op
// (insert or search) and a last-letter mark. A word yields exactly one result
// item on the rsp_ channel, given when its last letter has been processed; the
// other letters yield nothing. Both channels are valid/ready handshakes.
//
// Timing. An item is accepted only while the sequencer is idle. The accept
// cycle issues the child table read; the following cycle walks or allocates
// and writes back, and a letter that is not last then returns to idle. A last
// insert letter instead goes on to the emit state to stage the result; a last
// search letter that has not failed first visits the mark state for the
// registered read of the word-end mark. The single child table port and its
// registered read set this order: each lookup needs the previous letter's node.
//
// Reset. After reset the block runs a clearing pass over all NODES*ALPHABET
// child table entries, one entry a cycle, and clears the word-end marks
// alongside; req_ready is low until the pass is over.
//
// Stalls. The result sits in an output register, so new letters are accepted
// while it waits. A later result waits in the sequencer until the register frees.
module trie_word_insert_search_top
   import twis_pkg::*;
#(
   parameter int NODES    = DEFAULT_NODES,
   parameter int WORD_MAX = DEFAULT_WORD_MAX,
   parameter int ALPHABET = DEFAULT_ALPHABET
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_op,
   input  logic [LETTER_W-1:0] req_letter,
   input  logic                req_last_letter,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [STATUS_W-1:0] rsp_status
);

   localparam int DEPTH  = NODES * ALPHABET;
   localparam int NODE_W = $clog2(NODES);
   localparam int FREE_W = NODE_W + 1;
   localparam int SLOT_W = $clog2(DEPTH);
   localparam int POS_W  = $clog2(WORD_MAX + 1);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_LOOK,
      S_MARK,
      S_EMIT
   } state_type;

   state_type          state_ff, state_in;
   logic [SLOT_W-1:0]  clr_ff, clr_in;
   logic [FREE_W-1:0]  next_free_ff, next_free_in;
   logic [NODE_W-1:0]  cur_ff, cur_in;
   status_type         fail_ff, fail_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic               op_ff, op_in;
   logic               last_ff, last_in;
   status_type         status_ff, status_in;
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;

   // Memory ports.
   logic               child_we, child_re;
   logic [SLOT_W-1:0]  child_waddr, child_raddr;
   logic [NODE_W-1:0]  child_wdata, child_rdata;
   logic               mark_we, mark_re;
   logic [NODE_W-1:0]  mark_waddr, mark_raddr;
   logic               mark_wdata, mark_rdata;

   // Walk results of the lookup cycle.
   logic [LETTER_W-1:0] letter_sat;
   logic [SLOT_W-1:0]   slot_now;
   logic                accept;
   logic                alloc;
   logic                rsp_free;
   status_type          walk_fail;
   logic [NODE_W-1:0]   walk_cur;
   logic [POS_W-1:0]    walk_pos;

   assign accept   = req_valid && req_ready;
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   // Codes beyond the alphabet saturate to its last letter.
   assign letter_sat = (req_letter >= LETTER_W'(ALPHABET)) ? LETTER_W'(ALPHABET - 1)
                                                          : req_letter;
   assign slot_now = SLOT_W'(cur_ff) * SLOT_W'(ALPHABET) + SLOT_W'(letter_sat);

   // One letter step, evaluated while the child entry is on the read port.
   always_comb begin
      walk_fail = fail_ff;
      walk_cur  = cur_ff;
      walk_pos  = pos_ff;
      alloc     = 1'b0;
      if (pos_ff >= POS_W'(WORD_MAX)) begin
         // A letter past the limit overrides any earlier failure.
         walk_fail = STATUS_TOO_LONG;
      end else begin
         walk_pos = pos_ff + POS_W'(1);
         if (fail_ff == STATUS_OK) begin
            if (child_rdata == '0) begin
               if (op_ff == OP_SEARCH) begin
                  walk_fail = STATUS_NOT_FOUND;
               end else if (next_free_ff >= FREE_W'(NODES)) begin
                  walk_fail = STATUS_POOL_FULL;
               end else begin
                  alloc    = 1'b1;
                  walk_cur = next_free_ff[NODE_W-1:0];
               end
            end else begin
               walk_cur = child_rdata;
            end
         end
      end
   end

   // Memory control.
   always_comb begin
      child_re    = accept;
      child_raddr = slot_now;
      child_we    = 1'b0;
      child_waddr = slot_ff;
      child_wdata = next_free_ff[NODE_W-1:0];
      mark_we     = 1'b0;
      mark_waddr  = walk_cur;
      mark_wdata  = 1'b1;
      mark_re     = 1'b0;
      mark_raddr  = walk_cur;
      case (state_ff)
         S_CLEAR: begin
            child_we    = 1'b1;
            child_waddr = clr_ff;
            child_wdata = '0;
            mark_we     = clr_ff < SLOT_W'(NODES);
            mark_waddr  = clr_ff[NODE_W-1:0];
            mark_wdata  = 1'b0;
         end
         S_LOOK: begin
            child_we = alloc;
            if (last_ff && walk_fail == STATUS_OK) begin
               mark_we = op_ff == OP_INSERT;
               mark_re = op_ff == OP_SEARCH;
            end
         end
         default: begin
         end
      endcase
   end

   // Sequencer next state.
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      next_free_in  = next_free_ff;
      cur_in        = cur_ff;
      fail_in       = fail_ff;
      pos_in        = pos_ff;
      slot_in       = slot_ff;
      op_in         = op_ff;
      last_in       = last_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      req_ready     = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + SLOT_W'(1);
            if (clr_ff == SLOT_W'(DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               slot_in  = slot_now;
               op_in    = req_op;
               last_in  = req_last_letter;
               state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            if (alloc) begin
               next_free_in = next_free_ff + FREE_W'(1);
            end
            if (last_ff) begin
               // The word ends; the status is staged or looked up and the walk restarts.
               cur_in  = '0;
               fail_in = STATUS_OK;
               pos_in  = '0;
               if (walk_fail == STATUS_OK && op_ff == OP_SEARCH) begin
                  state_in = S_MARK;
               end else begin
                  status_in = walk_fail;
                  state_in  = S_EMIT;
               end
            end else begin
               cur_in   = walk_cur;
               fail_in  = walk_fail;
               pos_in   = walk_pos;
               state_in = S_IDLE;
            end
         end
         S_MARK: begin
            status_in = mark_rdata ? STATUS_OK : STATUS_NOT_FOUND;
            state_in  = S_EMIT;
         end
         S_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         next_free_ff <= FREE_W'(1);
         cur_ff       <= '0;
         fail_ff      <= STATUS_OK;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         next_free_ff <= next_free_in;
         cur_ff       <= cur_in;
         fail_ff      <= fail_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      slot_ff       <= slot_in;
      op_ff         <= op_in;
      last_ff       <= last_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;

   twis_ram #(
      .DEPTH  (DEPTH),
      .ADDR_W (SLOT_W),
      .DATA_W (NODE_W)
   ) u_child_ram (
      .clock   (clock),
      .wr_en   (child_we),
      .wr_addr (child_waddr),
      .wr_data (child_wdata),
      .rd_en   (child_re),
      .rd_addr (child_raddr),
      .rd_data (child_rdata)
   );

   twis_ram #(
      .DEPTH  (NODES),
      .ADDR_W (NODE_W),
      .DATA_W (1)
   ) u_mark_ram (
      .clock   (clock),
      .wr_en   (mark_we),
      .wr_addr (mark_waddr),
      .wr_data (mark_wdata),
      .rd_en   (mark_re),
      .rd_addr (mark_raddr),
      .rd_data (mark_rdata)
   );

   // No letter is taken while the clearing pass is still running.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |-> !req_ready)
      else $error("item accepted during clearing pass");

   // The free-node counter never runs past the pool.
   assert property (@(posedge clock) disable iff (reset)
      next_free_ff <= FREE_W'(NODES))
      else $error("free-node counter beyond pool");

   // A node is allocated only while the pool has room, and the counter moves with it.
   assert property (@(posedge clock) disable iff (reset)
      alloc && state_ff == S_LOOK |=> next_free_ff == $past(next_free_ff) + FREE_W'(1))
      else $error("allocation did not advance the free-node counter");

   // A staged result is never dropped: an occupied, stalled output register holds.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EMIT && !rsp_free |=> state_ff == S_EMIT)
      else $error("result left the sequencer while output was busy");

endmodule

@@ sim/trie_word_insert_search_checker.sv @@
// Checker for the trie word insert and search block: watches both channels,
// keeps its own copy of the trie and compares every status item in order.
// Depends on twis_pkg.
module trie_word_insert_search_checker
   import twis_pkg::*;
#(
   parameter int NODES    = DEFAULT_NODES,
   parameter int WORD_MAX = DEFAULT_WORD_MAX,
   parameter int ALPHABET = DEFAULT_ALPHABET
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  logic                req_op,
   input  logic [LETTER_W-1:0] req_letter,
   input  logic                req_last_letter,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  logic [STATUS_W-1:0] rsp_status,
   output int                  mismatch_count,
   output int                  pending_count,
   output int                  statuses_checked,
   output int                  pool_full_count
);

   // Shadow trie: child pointers (0 means no child), end marks and walk state.
   int unsigned child_of [NODES*ALPHABET];
   bit          word_end [NODES];
   int unsigned free_node;
   int unsigned cur_node;
   int unsigned letter_pos;
   status_type  word_fail;

   status_type  expected_status_q [$];
   status_type  want;

   initial begin
      mismatch_count   = 0;
      pending_count    = 0;
      statuses_checked = 0;
      pool_full_count  = 0;
   end

   // Walks or extends the shadow trie by one letter and, on a last letter,
   // queues the status the word should report.
   task automatic apply_letter(input logic op, input logic [LETTER_W-1:0] code,
                               input logic last);
      int unsigned letter;
      int unsigned slot;
      int unsigned child;
      status_type  status;
      begin
         letter = code;
         if (letter >= ALPHABET) letter = ALPHABET - 1;
         if (letter_pos >= WORD_MAX) begin
            word_fail = STATUS_TOO_LONG;
         end else begin
            letter_pos++;
            if (word_fail == STATUS_OK) begin
               slot  = cur_node * ALPHABET + letter;
               child = child_of[slot];
               if (child == 0) begin
                  if (op == OP_SEARCH) begin
                     word_fail = STATUS_NOT_FOUND;
                  end else if (free_node >= NODES) begin
                     word_fail = STATUS_POOL_FULL;
                  end else begin
                     child          = free_node;
                     child_of[slot] = child;
                     free_node++;
                  end
               end
               if (word_fail == STATUS_OK) cur_node = child;
            end
         end
         if (last) begin
            status = word_fail;
            if (status == STATUS_OK) begin
               if (op == OP_SEARCH) begin
                  status = word_end[cur_node] ? STATUS_OK : STATUS_NOT_FOUND;
               end else begin
                  word_end[cur_node] = 1'b1;
               end
            end
            expected_status_q.push_back(status);
            if (status == STATUS_POOL_FULL) pool_full_count++;
            cur_node   = 0;
            word_fail  = STATUS_OK;
            letter_pos = 0;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         foreach (child_of[i]) child_of[i] = 0;
         foreach (word_end[i]) word_end[i] = 1'b0;
         free_node  = 1;
         cur_node   = 0;
         letter_pos = 0;
         word_fail  = STATUS_OK;
         expected_status_q.delete();
         pending_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_status_q.size() == 0) begin
               if (mismatch_count < 10)
                  $display("Status item %0d with no word pending at cycle edge %0t",
                           rsp_status, $realtime);
               mismatch_count++;
            end else begin
               want = expected_status_q.pop_front();
               statuses_checked++;
               if (rsp_status !== want) begin
                  if (mismatch_count < 10)
                     $display("Status mismatch on word %0d: expected %0d, got %0d",
                              statuses_checked, want, rsp_status);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && req_ready) apply_letter(req_op, req_letter, req_last_letter);
         pending_count = expected_status_q.size();
      end
   end

endmodule

@@ sim/trie_word_insert_search_top_test.sv @@
// Testbench top for the trie word insert and search block: drives letters and
// the result handshake, and gives the verdict from the checker's counts.
// Depends on twis_pkg, trie_word_insert_search_top and trie_word_insert_search_checker.
module trie_word_insert_search_top_test;
   import twis_pkg::*;

   localparam int ITEM_TARGET = 1650;
   localparam int CYCLE_LIMIT = 400000;
   localparam int VOCAB_SIZE  = 32;
   localparam int MAX_LEN     = 20;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic                req_op;
   logic [LETTER_W-1:0] req_letter;
   logic                req_last_letter;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [STATUS_W-1:0] rsp_status;

   int mismatch_count;
   int pending_count;
   int statuses_checked;
   int pool_full_count;

   // Stimulus bookkeeping. The word buffer holds the letters of the word
   // about to be sent; the vocabulary holds words that recur through the run
   // so that searches hit stored words and prefixes share nodes.
   logic [LETTER_W-1:0] word_buf [MAX_LEN];
   logic [LETTER_W-1:0] vocab [VOCAB_SIZE][MAX_LEN];
   int                  vocab_len [VOCAB_SIZE];
   int                  burst_left;
   int                  letters_sent;
   int                  words_sent;
   int                  cycle_count;
   int                  stall_left;
   int                  stall_pct;
   int                  pick;
   int                  len;
   int                  v;
   int                  src;
   int                  keep;

   trie_word_insert_search_top uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_letter      (req_letter),
      .req_last_letter (req_last_letter),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status)
   );

   trie_word_insert_search_checker status_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_letter       (req_letter),
      .req_last_letter  (req_last_letter),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .mismatch_count   (mismatch_count),
      .pending_count    (pending_count),
      .statuses_checked (statuses_checked),
      .pool_full_count  (pool_full_count)
   );

   // Free-running clock with a period of 10.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog. The slowest correct run is the clearing pass after reset plus
   // every letter taking its longest path behind a full gap and a stalled
   // result; the limit is several times that.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d statuses outstanding",
                  cycle_count, pending_count);
         $display("Mismatches found");
         $finish;
      end
   end

   // Result side. The receiver is ready by default and now and then stalls
   // for a few cycles. The chance of a stall is redrawn from time to time, so the
   // run sees stretches with no stalls at all, light stalling and heavy
   // stalling, each landing on different phases of the sequencer.
   always @(negedge clock) begin
      if (cycle_count % 512 == 0) stall_pct = $urandom_range(0, 2) * 20;
      if (stall_left > 0) begin
         rsp_ready = 1'b0;
         stall_left--;
      end else begin
         rsp_ready = 1'b1;
         if ($urandom_range(0, 99) < stall_pct) stall_left = $urandom_range(1, 6);
      end
   end

   // Sends one letter. The sender works in bursts: when a burst runs out,
   // valid drops for a random gap before the next burst starts. Once valid is
   // raised it stays high with the same payload until the block takes the
   // item. Inputs change only at the falling edge; ready is sampled at the
   // rising edge.
   task automatic send_letter(input logic op, input logic [LETTER_W-1:0] code,
                              input logic last);
      int gap;
      begin
         if (burst_left == 0) begin
            gap       = $urandom_range(1, 10);
            req_valid = 1'b0;
            repeat (gap) @(negedge clock);
            burst_left = $urandom_range(1, 40);
         end
         req_valid       = 1'b1;
         req_op          = op;
         req_letter      = code;
         req_last_letter = last;
         @(posedge clock);
         while (!req_ready) @(posedge clock);
         @(negedge clock);
         burst_left--;
         letters_sent++;
      end
   endtask

   // Sends the first wlen letters of the word buffer as one word. A mixed word
   // picks the op of each letter at random; the op of the last letter then
   // decides whether the word is marked or looked up.
   task automatic send_word(input int wlen, input logic op, input bit mixed);
      logic letter_op;
      begin
         for (int i = 0; i < wlen; i++) begin
            letter_op = mixed ? logic'($urandom_range(0, 1)) : op;
            send_letter(letter_op, word_buf[i], i == wlen - 1);
         end
         words_sent++;
      end
   endtask

   // Vocabulary letters mostly come from a small set so that words share
   // prefixes; now and then a code from the whole 5-bit range shows up, which
   // includes the codes above z that the block folds onto z.
   function automatic logic [LETTER_W-1:0] pick_vocab_letter();
      if ($urandom_range(0, 7) == 0) return LETTER_W'($urandom_range(0, 31));
      return LETTER_W'($urandom_range(0, 5));
   endfunction

   initial begin
      clock           = 1'b0;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_op          = OP_INSERT;
      req_letter      = '0;
      req_last_letter = 1'b0;
      rsp_ready       = 1'b0;
      burst_left      = 0;
      letters_sent    = 0;
      words_sent      = 0;
      cycle_count     = 0;
      stall_left      = 0;
      stall_pct       = 0;

      // Build the vocabulary. About a third of the words reuse a prefix of an
      // earlier word, sometimes exactly, so that inserting a prefix of a
      // stored word and extending a stored word both occur.
      for (v = 0; v < VOCAB_SIZE; v++) begin
         if (v > 0 && $urandom_range(0, 2) == 0) begin
            src  = $urandom_range(0, v - 1);
            keep = $urandom_range(1, vocab_len[src]);
            for (int i = 0; i < keep; i++) vocab[v][i] = vocab[src][i];
            vocab_len[v] = keep + $urandom_range(0, 3);
            // Chains of extended words must still fit the word buffer.
            if (vocab_len[v] > MAX_LEN) vocab_len[v] = MAX_LEN;
            for (int i = keep; i < vocab_len[v]; i++) vocab[v][i] = pick_vocab_letter();
         end else begin
            vocab_len[v] = $urandom_range(1, 10);
            for (int i = 0; i < vocab_len[v]; i++) vocab[v][i] = pick_vocab_letter();
         end
      end

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed words. The block first clears its tables, so the first
      // letter waits on the handshake until that pass is over.
      // The lowest letter, stored and found again.
      word_buf[0] = 5'd0;
      send_word(1, OP_INSERT, 1'b0);
      send_word(1, OP_SEARCH, 1'b0);
      // The highest code folds onto z: absent first, then stored under the
      // out-of-range code and found under z itself.
      word_buf[0] = 5'd31;
      send_word(1, OP_SEARCH, 1'b0);
      send_word(1, OP_INSERT, 1'b0);
      word_buf[0] = 5'd25;
      send_word(1, OP_SEARCH, 1'b0);
      // A two-letter word, then its one-letter prefix inserted, which only
      // walks the existing node and marks it, then the prefix found.
      word_buf[0] = 5'd1;
      word_buf[1] = 5'd2;
      send_word(2, OP_INSERT, 1'b0);
      send_word(1, OP_INSERT, 1'b0);
      send_word(1, OP_SEARCH, 1'b0);
      // A mixed word whose search letter misses: the insert on the last
      // letter reports the stuck not-found failure.
      word_buf[0] = 5'd3;
      word_buf[1] = 5'd4;
      send_letter(OP_SEARCH, word_buf[0], 1'b0);
      send_letter(OP_INSERT, word_buf[1], 1'b1);
      words_sent++;
      // One letter past the word limit.
      for (int i = 0; i < 16; i++) word_buf[i] = LETTER_W'(i + 6);
      send_word(16, OP_INSERT, 1'b0);

      // Random words. Most come from the vocabulary so that searches find
      // real words and prefixes; the rest are random letter strings that use
      // up the node pool as the run goes on, and long words, some past the limit.
      while (letters_sent < ITEM_TARGET) begin
         pick = $urandom_range(0, 99);
         v    = $urandom_range(0, VOCAB_SIZE - 1);
         len  = vocab_len[v];
         for (int i = 0; i < len; i++) word_buf[i] = vocab[v][i];
         if (pick < 40) begin
            send_word(len, OP_INSERT, 1'b0);
         end else if (pick < 65) begin
            send_word(len, OP_SEARCH, 1'b0);
         end else if (pick < 75) begin
            send_word($urandom_range(1, len), OP_SEARCH, 1'b0);
         end else if (pick < 82) begin
            send_word(len, OP_INSERT, 1'b1);
         end else begin
            len = (pick < 93) ? $urandom_range(1, 10) : $urandom_range(14, 18);
            for (int i = 0; i < len; i++) word_buf[i] = LETTER_W'($urandom_range(0, 31));
            send_word(len, logic'($urandom_range(0, 1)), pick[0]);
         end
      end
      req_valid = 1'b0;

      // Drain: wait for every outstanding status, then a few more cycles in
      // case a stray item follows.
      while (pending_count != 0) @(negedge clock);
      repeat (12) @(negedge clock);

      $display("Drove %0d letters in %0d words; checked %0d statuses, %0d of them pool full.",
               letters_sent, words_sent, statuses_checked, pool_full_count);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("%0d status items disagreed with the prediction.", mismatch_count);
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
